// ===== rtl/core/utf8_stream_decoder_macros.svh =====
// ----------------------------------------------------------------------------
// utf8_stream_decoder_macros
// Assertion macros used by the decoder back end (utf8sd_back).
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_DECODER_MACROS_SVH
`define UTF8_STREAM_DECODER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define U8SD_ASSERT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while in reset.
`define U8SD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/utf8sd_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8sd_pkg
// Types and constants of the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package utf8sd_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CP_W  = 21;
    localparam int LEN_W = 3;

    localparam logic [CP_W-1:0] MIN_CP_2 = 21'h00080;
    localparam logic [CP_W-1:0] MIN_CP_3 = 21'h00800;
    localparam logic [CP_W-1:0] MIN_CP_4 = 21'h10000;
    localparam logic [CP_W-1:0] MAX_CP   = 21'h10FFFF;

    localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
    localparam logic [LEN_W-1:0] LEN_1    = 3'd1;
    localparam logic [LEN_W-1:0] LEN_2    = 3'd2;
    localparam logic [LEN_W-1:0] LEN_3    = 3'd3;
    localparam logic [LEN_W-1:0] LEN_4    = 3'd4;

    typedef enum logic [1:0] {
        ST_VALID      = 2'd0,
        ST_NULL       = 2'd1,
        ST_ILLEGAL    = 2'd2,
        ST_INCOMPLETE = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0]       data;
        logic             last;
        logic [LEN_W-1:0] lead_len;
        logic             is_cont;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

// ===== rtl/core/utf8sd_front.sv =====
// ----------------------------------------------------------------------------
// utf8sd_front
// Input side: takes bytes and tags each with its lead length and class.
// ----------------------------------------------------------------------------
module utf8sd_front (
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [7:0]            i_in_byte,
    input  logic                  i_end_of_input,
    input  utf8sd_pkg::t_qstat    i_qstat,
    output logic                  o_push,
    output utf8sd_pkg::t_item     o_item
);
    import utf8sd_pkg::*;

    logic [LEN_W-1:0] lead_len;

    always_comb begin
        priority if (i_in_byte[7] == 1'b0) begin
            lead_len = LEN_1;
        end else if (i_in_byte[7:5] == 3'b110) begin
            lead_len = LEN_2;
        end else if (i_in_byte[7:4] == 4'b1110) begin
            lead_len = LEN_3;
        end else if (i_in_byte[7:3] == 5'b11110) begin
            lead_len = LEN_4;
        end else begin
            lead_len = LEN_NONE;
        end
    end

    assign o_ready          = !i_qstat.full;
    assign o_push           = i_valid && !i_qstat.full;
    assign o_item.data      = i_in_byte;
    assign o_item.last      = i_end_of_input;
    assign o_item.lead_len  = lead_len;
    assign o_item.is_cont   = (i_in_byte[7:6] == 2'b10);

endmodule

// ===== rtl/core/utf8sd_queue.sv =====
// ----------------------------------------------------------------------------
// utf8sd_queue
// Short FIFO of tagged bytes between front and back.
// ----------------------------------------------------------------------------
module utf8sd_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  utf8sd_pkg::t_item     i_item,
    input  logic                  i_pop,
    output utf8sd_pkg::t_item     o_item,
    output utf8sd_pkg::t_qstat    o_qstat
);
    import utf8sd_pkg::*;

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;
    logic [QCNT_W-1:0] n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assign o_item        = r_mem[r_rd_ptr];
    assign o_qstat.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_qstat.empty = (r_count == '0);

endmodule

// ===== rtl/core/utf8sd_back.sv =====
// ----------------------------------------------------------------------------
// utf8sd_back
// Sequence state machine and registered result slot.
// ----------------------------------------------------------------------------
`include "utf8_stream_decoder_macros.svh"

module utf8sd_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  utf8sd_pkg::t_item     i_item,
    input  utf8sd_pkg::t_qstat    i_qstat,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [20:0]           o_code_point,
    output logic [2:0]            o_seq_length,
    output logic [1:0]            o_status
);
    import utf8sd_pkg::*;

    logic [LEN_W-1:0] r_exp_len;
    logic [LEN_W-1:0] r_seen;
    logic [CP_W-1:0]  r_partial;
    logic             r_bad;
    logic             r_out_valid;
    logic [CP_W-1:0]  r_cp;
    logic [LEN_W-1:0] r_len;
    t_status          r_st;

    logic [LEN_W-1:0] n_exp_len;
    logic [LEN_W-1:0] n_seen;
    logic [CP_W-1:0]  n_partial;
    logic             n_bad;
    logic             emit;
    logic [CP_W-1:0]  emit_cp;
    logic [LEN_W-1:0] emit_len;
    t_status          emit_st;
    logic [CP_W-1:0]  lead_bits;
    logic             range_bad;

    assign o_pop = !i_qstat.empty && (!r_out_valid || i_ready);

    always_comb begin
        unique case (i_item.lead_len)
            LEN_2:   lead_bits = CP_W'(i_item.data[4:0]);
            LEN_3:   lead_bits = CP_W'(i_item.data[3:0]);
            LEN_4:   lead_bits = CP_W'(i_item.data[2:0]);
            default: lead_bits = CP_W'(i_item.data);
        endcase
    end

    always_comb begin
        n_exp_len = r_exp_len;
        n_seen    = r_seen;
        n_partial = r_partial;
        n_bad     = r_bad;
        emit      = 1'b0;
        emit_cp   = '0;
        emit_len  = LEN_NONE;
        emit_st   = ST_VALID;
        range_bad = 1'b0;
        if (r_exp_len == LEN_NONE) begin
            priority if (i_item.lead_len == LEN_NONE) begin
                emit    = 1'b1;
                emit_st = ST_ILLEGAL;
            end else if (i_item.lead_len == LEN_1) begin
                emit = 1'b1;
                if (i_item.data == 8'h00) begin
                    emit_st = ST_NULL;
                end else begin
                    emit_cp  = CP_W'(i_item.data);
                    emit_len = LEN_1;
                end
            end else begin
                n_exp_len = i_item.lead_len;
                n_seen    = LEN_1;
                n_partial = lead_bits;
                n_bad     = 1'b0;
                if (i_item.last) begin
                    emit    = 1'b1;
                    emit_st = ST_INCOMPLETE;
                end
            end
        end else begin
            n_bad     = r_bad || !i_item.is_cont;
            n_partial = {r_partial[CP_W-7:0], i_item.data[5:0]};
            n_seen    = r_seen + 1'b1;
            unique case (r_exp_len)
                LEN_2:   range_bad = (n_partial < MIN_CP_2);
                LEN_3:   range_bad = (n_partial < MIN_CP_3);
                default: range_bad = (n_partial < MIN_CP_4) || (n_partial > MAX_CP);
            endcase
            if (n_seen >= r_exp_len) begin
                emit = 1'b1;
                if (n_bad || range_bad) begin
                    emit_st = ST_ILLEGAL;
                end else begin
                    emit_cp  = n_partial;
                    emit_len = r_exp_len;
                end
            end else if (i_item.last) begin
                emit    = 1'b1;
                emit_st = ST_INCOMPLETE;
            end
        end
        if (emit) begin
            n_exp_len = LEN_NONE;
            n_seen    = LEN_NONE;
            n_partial = '0;
            n_bad     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_len   <= LEN_NONE;
            r_seen      <= LEN_NONE;
            r_partial   <= '0;
            r_bad       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_exp_len <= n_exp_len;
                r_seen    <= n_seen;
                r_partial <= n_partial;
                r_bad     <= n_bad;
            end
            if (o_pop) begin
                r_out_valid <= emit;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_cp  <= emit_cp;
            r_len <= emit_len;
            r_st  <= emit_st;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_code_point = r_cp;
    assign o_seq_length = r_len;
    assign o_status     = r_st;

    `U8SD_ASSERT(a_err_zero, i_clk, i_rst_n, r_out_valid && r_st != ST_VALID, r_cp == '0 && r_len == LEN_NONE)
    `U8SD_ASSERT(a_idle_clear, i_clk, i_rst_n, r_exp_len == LEN_NONE, r_seen == LEN_NONE && !r_bad)
    `U8SD_ASSERT(a_seen_range, i_clk, i_rst_n, r_exp_len != LEN_NONE, r_seen != LEN_NONE && r_seen < r_exp_len)
    `U8SD_ASSERT_NEXT(a_open_seq, i_clk, i_rst_n, o_pop && r_exp_len == LEN_NONE && i_item.lead_len >= LEN_2 && !i_item.last, r_exp_len != LEN_NONE && !r_bad)

endmodule

// ===== rtl/core/utf8_stream_decoder.sv =====
// Path: an accepted byte is written into the byte queue; when popped, any result it completes is registered.
// Throughput: one byte per cycle while the receiver does not stall; the byte queue and the result register
// decouple the input and output handshakes.
// Reset: synchronous, active low; clears sequence state, queue and result valid.
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// UTF-8 byte stream to code point decoder with error and incomplete status.
// ----------------------------------------------------------------------------
module utf8_stream_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_end_of_input,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [20:0] o_code_point,
    output logic [2:0]  o_seq_length,
    output logic [1:0]  o_status
);
    import utf8sd_pkg::*;

    logic   push;
    logic   pop;
    t_item  push_item;
    t_item  head_item;
    t_qstat qstat;

    utf8sd_front u_front (
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_in_byte      (i_in_byte),
        .i_end_of_input (i_end_of_input),
        .i_qstat        (qstat),
        .o_push         (push),
        .o_item         (push_item)
    );

    utf8sd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (head_item),
        .o_qstat (qstat)
    );

    utf8sd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (head_item),
        .i_qstat      (qstat),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_code_point (o_code_point),
        .o_seq_length (o_seq_length),
        .o_status     (o_status)
    );

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for utf8_stream_decoder. A queue of stream bytes feeds
// a valid/ready driver; every accepted byte runs through a local decoder
// model and any result it produces is queued, then matched field by field
// against the output items. Traffic runs through phases of free flow, sender
// gaps, receiver stalls and both, after a directed set of corner cases.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import utf8sd_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int LIMIT_CYCLES = 200000;
    localparam int PHASE_BYTES  = 100;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_stream_byte;

    typedef struct {
        logic [CP_W-1:0]  cp;
        logic [LEN_W-1:0] seq_len;
        t_status          status;
    } t_decoded;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_valid        = 1'b0;
    logic        o_ready;
    logic [7:0]  i_in_byte      = '0;
    logic        i_end_of_input = 1'b0;
    logic        o_valid;
    logic        i_ready        = 1'b0;
    logic [20:0] o_code_point;
    logic [2:0]  o_seq_length;
    logic [1:0]  o_status;

    t_stream_byte byte_q[$];
    t_decoded     expected_q[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int errors         = 0;
    int bytes_sent     = 0;
    int results_seen   = 0;
    int cycles         = 0;
    int status_count[4];

    // decoder model state
    logic [LEN_W-1:0] open_len    = LEN_NONE;
    logic [LEN_W-1:0] bytes_taken = '0;
    logic [CP_W-1:0]  payload_acc = '0;
    logic             cont_error  = 1'b0;

    utf8_stream_decoder dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_in_byte      (i_in_byte),
        .i_end_of_input (i_end_of_input),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_code_point   (o_code_point),
        .o_seq_length   (o_seq_length),
        .o_status       (o_status)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    task automatic decode_byte(input logic [7:0] b, input logic last);
        logic [LEN_W-1:0] lead;
        t_decoded         res;
        logic             done;
        done        = 1'b0;
        res.cp      = '0;
        res.seq_len = LEN_NONE;
        res.status  = ST_VALID;
        if (open_len == LEN_NONE) begin
            casez (b)
                8'b0???????: lead = LEN_1;
                8'b110?????: lead = LEN_2;
                8'b1110????: lead = LEN_3;
                8'b11110???: lead = LEN_4;
                default:     lead = LEN_NONE;
            endcase
            if (lead == LEN_NONE) begin
                res.status = ST_ILLEGAL;
                done       = 1'b1;
            end else if (lead == LEN_1) begin
                if (b == 8'h00) begin
                    res.status = ST_NULL;
                end else begin
                    res.cp      = CP_W'(b);
                    res.seq_len = LEN_1;
                end
                done = 1'b1;
            end else begin
                open_len    = lead;
                bytes_taken = LEN_W'(1);
                payload_acc = CP_W'(b & (8'hFF >> (lead + 1)));
                cont_error  = 1'b0;
                if (last) begin
                    res.status = ST_INCOMPLETE;
                    done       = 1'b1;
                end
            end
        end else begin
            if (b[7:6] != 2'b10)
                cont_error = 1'b1;
            payload_acc = {payload_acc[CP_W-7:0], b[5:0]};
            bytes_taken = bytes_taken + 1'b1;
            if (bytes_taken >= open_len) begin
                done = 1'b1;
                if (cont_error
                    || (open_len == LEN_2 && payload_acc < MIN_CP_2)
                    || (open_len == LEN_3 && payload_acc < MIN_CP_3)
                    || (open_len == LEN_4 && (payload_acc < MIN_CP_4 || payload_acc > MAX_CP)))
                begin
                    res.status = ST_ILLEGAL;
                end else begin
                    res.cp      = payload_acc;
                    res.seq_len = open_len;
                end
            end else if (last) begin
                res.status = ST_INCOMPLETE;
                done       = 1'b1;
            end
        end
        if (done) begin
            expected_q.push_back(res);
            open_len    = LEN_NONE;
            bytes_taken = '0;
            payload_acc = '0;
            cont_error  = 1'b0;
        end
    endtask

    // driver: valid holds with a stable payload until the item is taken
    always @(posedge i_clk) begin : drive
        t_stream_byte nxt;
        logic         fire;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            fire = i_valid && o_ready;
            if (fire) begin
                decode_byte(i_in_byte, i_end_of_input);
                bytes_sent++;
            end
            if (!i_valid || fire) begin
                if (byte_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = byte_q.pop_front();
                    i_valid        <= 1'b1;
                    i_in_byte      <= nxt.data;
                    i_end_of_input <= nxt.last;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin : check
        t_decoded exp_res;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                results_seen++;
                status_count[o_status]++;
                if (expected_q.size() == 0) begin
                    $display("%0t: result with none expected: cp=%h len=%0d status=%0d",
                             $realtime, o_code_point, o_seq_length, o_status);
                    errors++;
                end else begin
                    exp_res = expected_q.pop_front();
                    if (o_code_point !== exp_res.cp) begin
                        $display("%0t: code_point expected %h actual %h",
                                 $realtime, exp_res.cp, o_code_point);
                        errors++;
                    end
                    if (o_seq_length !== exp_res.seq_len) begin
                        $display("%0t: seq_length expected %0d actual %0d",
                                 $realtime, exp_res.seq_len, o_seq_length);
                        errors++;
                    end
                    if (o_status !== exp_res.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $realtime, exp_res.status, o_status);
                        errors++;
                    end
                end
            end
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycles, expected_q.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic add_byte(input logic [7:0] data, input logic last);
        t_stream_byte sb;
        sb.data = data;
        sb.last = last;
        byte_q.push_back(sb);
    endtask

    // Encode cp in n bytes, emit the first cut of them, optionally corrupt
    // byte bad_idx into a non-continuation byte, flag end on the final one.
    task automatic add_seq(input logic [20:0] cp, input int n, input bit end_flag,
                           input int cut, input int bad_idx);
        logic [7:0] b[4];
        logic [7:0] nb;
        case (n)
            1: b[0] = {1'b0, cp[6:0]};
            2: begin
                b[0] = {3'b110, cp[10:6]};
                b[1] = {2'b10, cp[5:0]};
            end
            3: begin
                b[0] = {4'b1110, cp[15:12]};
                b[1] = {2'b10, cp[11:6]};
                b[2] = {2'b10, cp[5:0]};
            end
            default: begin
                b[0] = {5'b11110, cp[20:18]};
                b[1] = {2'b10, cp[17:12]};
                b[2] = {2'b10, cp[11:6]};
                b[3] = {2'b10, cp[5:0]};
            end
        endcase
        if (bad_idx > 0) begin
            nb = 8'($urandom);
            if (nb[7:6] == 2'b10)
                nb[6] = 1'b1;
            b[bad_idx] = nb;
        end
        for (int i = 0; i < cut; i++)
            add_byte(b[i], end_flag && (i == cut - 1));
    endtask

    function automatic int unsigned random_cp(input int n);
        case (n)
            1:       return $urandom_range(32'h7F, 0);
            2:       return $urandom_range(32'h7FF, 32'h80);
            3:       return $urandom_range(32'hFFFF, 32'h800);
            default: return ($urandom_range(9) == 0) ? $urandom_range(32'h1FFFFF, 32'h110000)
                                                     : $urandom_range(32'h10FFFF, 32'h10000);
        endcase
    endfunction

    task automatic add_random(input int n_bytes);
        int target;
        int kind;
        int n;
        int cut;
        int bad;
        int unsigned cp;
        target = byte_q.size() + n_bytes;
        while (byte_q.size() < target) begin
            kind = $urandom_range(99);
            n    = $urandom_range(4, 2);
            if (kind < 55) begin
                n = $urandom_range(4, 1);
                add_seq(21'(random_cp(n)), n, $urandom_range(9) == 0, n, 0);
            end else if (kind < 65) begin
                // overlong form
                cp = (n == 2) ? $urandom_range(32'h7F, 0)
                   : (n == 3) ? $urandom_range(32'h7FF, 0) : $urandom_range(32'hFFFF, 0);
                add_seq(21'(cp), n, $urandom_range(9) == 0, n, 0);
            end else if (kind < 75) begin
                // cut short by end of input, sometimes with a bad byte pending
                cut = $urandom_range(n - 1, 1);
                bad = (cut > 1 && $urandom_range(1) == 1) ? $urandom_range(cut - 1, 1) : 0;
                add_seq(21'(random_cp(n)), n, 1'b1, cut, bad);
            end else if (kind < 85) begin
                add_seq(21'(random_cp(n)), n, $urandom_range(9) == 0, n,
                        $urandom_range(n - 1, 1));
            end else begin
                add_byte(8'($urandom), $urandom_range(3) == 0);
            end
        end
    endtask

    task automatic wait_drained();
        while (byte_q.size() > 0 || i_valid || expected_q.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        // null, single byte with end flag, illegal leads
        add_byte(8'h00, 1'b0);
        add_byte(8'h7F, 1'b1);
        add_byte(8'h80, 1'b0);
        add_byte(8'hFF, 1'b1);
        // lead byte with end flag
        add_byte(8'hC2, 1'b1);
        // overlong two-byte
        add_seq(21'h000000, 2, 1'b0, 2, 0);
        // bad continuation reported at sequence end
        add_byte(8'hE2, 1'b0);
        add_byte(8'h41, 1'b0);
        add_byte(8'hAC, 1'b0);
        // end inside a sequence beats a pending bad continuation
        add_byte(8'hE2, 1'b0);
        add_byte(8'h41, 1'b1);
        // above the last code point
        add_seq(21'h110000, 4, 1'b0, 4, 0);
        // four-byte, surrogate, top of two-byte range
        add_seq(21'h01F600, 4, 1'b0, 4, 0);
        add_seq(21'h00D800, 3, 1'b0, 3, 0);
        add_seq(21'h0007FF, 2, 1'b0, 2, 0);

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                1:       begin send_idle_pct = 66; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 66; end
                3:       begin send_idle_pct = 28; recv_stall_pct = 28; end
                default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            endcase
            add_random(PHASE_BYTES * 4 / 5);
            // sender holds off until every result is back
            wait_drained();
        end

        repeat (20) @(posedge i_clk);
        if (expected_q.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $realtime, expected_q.size());
            errors++;
        end

        $display("Ran %0d bytes, checked %0d results: %0d valid, %0d null, %0d illegal,",
                 bytes_sent, results_seen, status_count[ST_VALID], status_count[ST_NULL],
                 status_count[ST_ILLEGAL]);
        $display("%0d incomplete; phases: free flow, sender gaps, receiver stalls, both",
                 status_count[ST_INCOMPLETE]);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
